// ===== src/bb3_pkg.sv =====
package bb3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 13;
    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 11'd1024;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 13'd768;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int FIFO_DEPTH  = 8;
    localparam int PSUM_W      = 10;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = 13;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 17;

    localparam logic FUNC_PIXEL = 1'b0;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // index 0 is the row two back, 2 the current row
    typedef pixel_t [2:0] column_t;

    typedef struct packed {
        logic [PSUM_W-1:0] red;
        logic [PSUM_W-1:0] green;
        logic [PSUM_W-1:0] blue;
    } psum_t;

    typedef struct packed {
        logic [2:0] row_ok;
        logic       col_ok;
    } cell_mask_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [2:0]       row_ok;
        logic [2:0]       col_ok;
        logic [CNT_W-1:0] count;
    } item_ctl_t;

    typedef struct packed {
        logic [NUM_W-1:0] red;
        logic [NUM_W-1:0] green;
        logic [NUM_W-1:0] blue;
    } num_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } result_t;

    // ceil(2^17 / (2 * count))
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

    // num = 2 * sum + count, quotient of num / (2 * count)
    function automatic logic [7:0] div_round(input logic [NUM_W-1:0] num,
                                             input logic [CNT_W-1:0] count);
        logic [NUM_W+RECIP_W-1:0] prod;
        prod = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(recip(count));
        return prod[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

endpackage

// ===== src/bb3_in_if.sv =====
interface bb3_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (
        output valid,
        output func,
        output in_red,
        output in_green,
        output in_blue,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  in_red,
        input  in_green,
        input  in_blue,
        output ready
    );
endinterface

// ===== src/bb3_out_if.sv =====
interface bb3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_frame;

    modport source (
        output valid,
        output out_red,
        output out_green,
        output out_blue,
        output last_of_frame,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_red,
        input  out_green,
        input  out_blue,
        input  last_of_frame,
        output ready
    );
endinterface

// ===== src/bb3_ram.sv =====
module bb3_ram #(
    parameter int WIDTH = $bits(bb3_pkg::pixel_t),
    parameter int DEPTH = bb3_pkg::MAX_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== src/bb3_col_cell.sv =====
module bb3_col_cell (
    input  logic                clk,
    input  logic                shift,
    input  bb3_pkg::column_t    col_in,
    input  bb3_pkg::cell_mask_t mask,
    output bb3_pkg::column_t    col_out,
    output bb3_pkg::psum_t      psum
);
    import bb3_pkg::*;

    column_t col_reg;
    psum_t   psum_reg;
    psum_t   psum_next;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
        psum_reg <= psum_next;
    end

    // masked column sum over the rows inside the image
    always_comb
    begin
        psum_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (mask.row_ok[i] && mask.col_ok)
            begin
                psum_next.red   = psum_next.red   + PSUM_W'(col_reg[i].red);
                psum_next.green = psum_next.green + PSUM_W'(col_reg[i].green);
                psum_next.blue  = psum_next.blue  + PSUM_W'(col_reg[i].blue);
            end
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;
endmodule

// ===== src/bb3_out_fifo.sv =====
module bb3_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bb3_pkg::result_t  push_data,
    bb3_out_if.source         deq
);
    import bb3_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    result_t      slot_reg [FIFO_DEPTH];
    logic [PW:0]  wr_ptr_reg;
    logic [PW:0]  wr_ptr_next;
    logic [PW:0]  rd_ptr_reg;
    logic [PW:0]  rd_ptr_next;
    logic         pop;
    result_t      head;

    assign pop = deq.valid && deq.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + (PW+1)'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg[PW-1:0]] <= push_data;
        end
    end

    assign head              = slot_reg[rd_ptr_reg[PW-1:0]];
    assign deq.valid         = wr_ptr_reg != rd_ptr_reg;
    assign deq.out_red       = head.red;
    assign deq.out_green     = head.green;
    assign deq.out_blue      = head.blue;
    assign deq.last_of_frame = head.last;
endmodule

// ===== src/box_blur_3x3_edge_aware_unit.sv =====
// channel   dir   protocol     contents
// pixels    in    valid/ready  func, in_red, in_green, in_blue
// blurred   out   valid/ready  out_red, out_green, out_blue, last_of_frame
// apb       in    psel/penable image_width at 0x0, image_height at 0x4
//
// one transaction per cycle in steady state while pixels.ready is high; the
// transaction that completes a window sends its result through the line store
// read, the column cell chain, the adder stage and the reciprocal multiply
// rst_n is asynchronous; line stores are not cleared, out-of-image rows
// and columns are masked
// pixels.ready drops while 8 results are reserved in the pipeline or queue
module box_blur_3x3_edge_aware_unit #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bb3_in_if.sink                      pixels,
    bb3_out_if.source                   blurred,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bb3_pkg::PADDR_W-1:0] paddr,
    input  logic [bb3_pkg::PDATA_W-1:0] pwdata,
    output logic [bb3_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import bb3_pkg::*;

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW    = AW + 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int RSV_W = $clog2(FIFO_DEPTH + 1);

    // configuration
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    logic                    cfg_wr;
    reg_idx_t                cfg_idx;
    logic [31:0]             w_full;
    logic [31:0]             h_full;
    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;

    // input side
    logic [AW-1:0]    ci_reg;
    logic [AW-1:0]    ci_next;
    logic [RW-1:0]    ri_reg;
    logic [RW-1:0]    ri_next;
    logic [RW-1:0]    h_ext;
    logic [CW-1:0]    ci_inc;
    logic             accept;
    logic             drain;
    logic             adv;
    logic             edge_hit;
    logic             norm_hit;
    logic             emit;
    logic             last;
    logic             rok0;
    logic             rok2;
    logic             cok0;
    logic [1:0]       rows;
    logic [1:0]       cols;
    pixel_t           in_px;
    item_ctl_t        ctl_now;
    logic [RSV_W-1:0] reserved_reg;
    logic [RSV_W-1:0] reserved_next;
    logic             pop;

    // pipeline
    logic             s1_vld_reg;
    logic [AW-1:0]    s1_addr_reg;
    pixel_t           s1_px_reg;
    item_ctl_t        s1_ctl_reg;
    pixel_t           up_rd;
    pixel_t           mid_rd;
    pixel_t           up_eff;
    pixel_t           mid_eff;
    logic             fwd_vld_reg;
    logic             fwd_vld_next;
    pixel_t           fwd_up_reg;
    pixel_t           fwd_mid_reg;
    column_t          new_col;
    column_t          col2;
    column_t          col1;
    column_t          col0;
    psum_t            psum2;
    psum_t            psum1;
    psum_t            psum0;
    cell_mask_t       mask2;
    cell_mask_t       mask1;
    cell_mask_t       mask0;
    logic             s2_vld_reg;
    item_ctl_t        s2_ctl_reg;
    logic             s3_vld_reg;
    item_ctl_t        s3_ctl_reg;
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    num_t             num_now;
    logic             s4_vld_reg;
    item_ctl_t        s4_ctl_reg;
    num_t             s4_num_reg;
    result_t          res_now;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMG_WIDTH_RST;
            height_reg <= IMG_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[IMG_WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[IMG_HEIGHT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg == '0)
            w_full = 32'd1;
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_full = 32'(MAX_WIDTH);
        else
            w_full = 32'(width_reg);

        priority if (height_reg == '0)
            h_full = 32'd1;
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_full = 32'(MAX_HEIGHT);
        else
            h_full = 32'(height_reg);
    end

    assign w_eff = w_full[WW-1:0];
    assign h_eff = h_full[HW-1:0];
    assign h_ext = RW'(h_eff);

    // input position and window masks
    assign accept   = pixels.valid && pixels.ready;
    assign drain    = ri_reg >= h_ext;
    assign adv      = drain || (pixels.func == FUNC_PIXEL);
    assign edge_hit = (ci_reg == '0) && (ri_reg >= RW'(2));
    assign norm_hit = (ci_reg != '0) && (ri_reg >= RW'(1));
    assign emit     = adv && (edge_hit || norm_hit);
    assign last     = edge_hit && (ri_reg == h_ext + RW'(1));
    assign rok0     = edge_hit ? (ri_reg >= RW'(3)) : (ri_reg >= RW'(2));
    assign rok2     = edge_hit ? (ri_reg <= h_ext) : !drain;
    assign cok0     = edge_hit ? (CW'(w_eff) >= CW'(2)) : (CW'(ci_reg) >= CW'(2));
    assign rows     = 2'd1 + 2'(rok0) + 2'(rok2);
    assign cols     = 2'd1 + 2'(cok0) + 2'(!edge_hit);
    assign ci_inc   = CW'(ci_reg) + CW'(1);

    always_comb
    begin
        ctl_now.emit   = emit;
        ctl_now.last   = last;
        ctl_now.row_ok = {rok2, 1'b1, rok0};
        ctl_now.col_ok = {!edge_hit, 1'b1, cok0};
        ctl_now.count  = {2'b00, rows} * {2'b00, cols};
    end

    always_comb
    begin
        in_px.red   = pixels.in_red;
        in_px.green = pixels.in_green;
        in_px.blue  = pixels.in_blue;
        if (drain)
        begin
            in_px = '0;
        end
    end

    always_comb
    begin
        ci_next = ci_reg;
        ri_next = ri_reg;
        priority if (cfg_wr)
        begin
            ci_next = '0;
            ri_next = '0;
        end
        else if (accept && adv)
        begin
            priority if (emit && last)
            begin
                ci_next = '0;
                ri_next = '0;
            end
            else if (ci_inc >= CW'(w_eff))
            begin
                ci_next = '0;
                ri_next = ri_reg + RW'(1);
            end
            else
            begin
                ci_next = ci_inc[AW-1:0];
            end
        end
    end

    // results promised to the output queue
    assign pop = blurred.valid && blurred.ready;

    always_comb
    begin
        reserved_next = reserved_reg;
        if (accept && emit)
        begin
            reserved_next = reserved_next + RSV_W'(1);
        end
        if (pop)
        begin
            reserved_next = reserved_next - RSV_W'(1);
        end
    end

    assign pixels.ready = reserved_reg < RSV_W'(FIFO_DEPTH);

    // line stores with write-to-read forwarding on a same-address collision
    assign fwd_vld_next = s1_vld_reg && accept && adv && (s1_addr_reg == ci_reg);
    assign up_eff       = fwd_vld_reg ? fwd_up_reg  : up_rd;
    assign mid_eff      = fwd_vld_reg ? fwd_mid_reg : mid_rd;

    bb3_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk     (clk),
        .wr_en   (s1_vld_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_eff),
        .rd_en   (accept && adv),
        .rd_addr (ci_reg),
        .rd_data (up_rd)
    );

    bb3_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_middle_store (
        .clk     (clk),
        .wr_en   (s1_vld_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_px_reg),
        .rd_en   (accept && adv),
        .rd_addr (ci_reg),
        .rd_data (mid_rd)
    );

    // window: chain of three column cells, newest column enters on the right
    always_comb
    begin
        new_col[0] = up_eff;
        new_col[1] = mid_eff;
        new_col[2] = s1_px_reg;
    end

    assign mask2 = '{row_ok: s2_ctl_reg.row_ok, col_ok: s2_ctl_reg.col_ok[2]};
    assign mask1 = '{row_ok: s2_ctl_reg.row_ok, col_ok: s2_ctl_reg.col_ok[1]};
    assign mask0 = '{row_ok: s2_ctl_reg.row_ok, col_ok: s2_ctl_reg.col_ok[0]};

    bb3_col_cell u_cell2 (
        .clk     (clk),
        .shift   (s1_vld_reg),
        .col_in  (new_col),
        .mask    (mask2),
        .col_out (col2),
        .psum    (psum2)
    );

    bb3_col_cell u_cell1 (
        .clk     (clk),
        .shift   (s1_vld_reg),
        .col_in  (col2),
        .mask    (mask1),
        .col_out (col1),
        .psum    (psum1)
    );

    bb3_col_cell u_cell0 (
        .clk     (clk),
        .shift   (s1_vld_reg),
        .col_in  (col1),
        .mask    (mask0),
        .col_out (col0),
        .psum    (psum0)
    );

    // window sum and rounding numerator
    assign sum_red   = SUM_W'(psum0.red) + SUM_W'(psum1.red) + SUM_W'(psum2.red)
                     + SUM_W'(col0[0].red & 8'h00);
    assign sum_green = SUM_W'(psum0.green) + SUM_W'(psum1.green) + SUM_W'(psum2.green);
    assign sum_blue  = SUM_W'(psum0.blue) + SUM_W'(psum1.blue) + SUM_W'(psum2.blue);

    always_comb
    begin
        num_now.red   = {sum_red, 1'b0} + NUM_W'(s3_ctl_reg.count);
        num_now.green = {sum_green, 1'b0} + NUM_W'(s3_ctl_reg.count);
        num_now.blue  = {sum_blue, 1'b0} + NUM_W'(s3_ctl_reg.count);
    end

    // reciprocal multiply into the output queue
    always_comb
    begin
        res_now.red   = div_round(s4_num_reg.red, s4_ctl_reg.count);
        res_now.green = div_round(s4_num_reg.green, s4_ctl_reg.count);
        res_now.blue  = div_round(s4_num_reg.blue, s4_ctl_reg.count);
        res_now.last  = s4_ctl_reg.last;
    end

    bb3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_vld_reg),
        .push_data (res_now),
        .deq       (blurred)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg       <= '0;
            ri_reg       <= '0;
            reserved_reg <= '0;
            s1_vld_reg   <= 1'b0;
            fwd_vld_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
        end
        else
        begin
            ci_reg       <= ci_next;
            ri_reg       <= ri_next;
            reserved_reg <= reserved_next;
            s1_vld_reg   <= accept && adv;
            fwd_vld_reg  <= fwd_vld_next;
            s2_vld_reg   <= s1_vld_reg && s1_ctl_reg.emit;
            s3_vld_reg   <= s2_vld_reg;
            s4_vld_reg   <= s3_vld_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && adv)
        begin
            s1_addr_reg <= ci_reg;
            s1_px_reg   <= in_px;
            s1_ctl_reg  <= ctl_now;
        end
        fwd_up_reg  <= mid_eff;
        fwd_mid_reg <= s1_px_reg;
        s2_ctl_reg  <= s1_ctl_reg;
        s3_ctl_reg  <= s2_ctl_reg;
        s4_ctl_reg  <= s3_ctl_reg;
        s4_num_reg  <= num_now;
    end

`ifndef ASSERT_OFF
    a_push_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |-> (reserved_reg != '0))
        else $error("result pushed without a reserved queue slot");

    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        blurred.valid |-> (reserved_reg != '0))
        else $error("queued result not covered by the reservation count");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && last) |=> ((ri_reg == '0) && (ci_reg == '0)))
        else $error("frame position not cleared after the final result");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ri_reg <= (h_ext + RW'(1)))
        else $error("input row ran past the drain row");
`endif
endmodule

// ===== tb/box_blur_3x3_edge_aware_unit_tb.sv =====
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_unit_tb;

    import bb3_pkg::*;

    localparam logic FUNC_FLUSH   = 1'b1;
    localparam int   ITEM_TARGET  = 1950;
    localparam int   STALL_LIMIT  = 2000;
    localparam int   SETTLE_CYC   = 10;
    localparam int   FULL_FRAME_MAX = 300;

    class box_blur_scoreboard;
        logic [23:0]      upper_row [MAX_WIDTH_DEF];
        logic [23:0]      middle_row [MAX_WIDTH_DEF];
        logic [8:0][23:0] win;
        int               col;
        int               row;
        int               width_reg;
        int               height_reg;
        result_t          blurred_q[$];
        int               errors;

        function new();
            for (int i = 0; i < MAX_WIDTH_DEF; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            win        = '0;
            width_reg  = int'(IMG_WIDTH_RST);
            height_reg = int'(IMG_HEIGHT_RST);
            col        = 0;
            row        = 0;
            errors     = 0;
        endfunction

        function int eff_width();
            if (width_reg == 0)
                return 1;
            return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
        endfunction

        function int eff_height();
            if (height_reg == 0)
                return 1;
            return (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
        endfunction

        // a register write aborts the frame in progress
        function void set_reg(reg_idx_t idx, logic [31:0] value);
            if (idx == REG_WIDTH)
                width_reg = int'(value[IMG_WIDTH_W-1:0]);
            else
                height_reg = int'(value[IMG_HEIGHT_W-1:0]);
            col = 0;
            row = 0;
        endfunction

        function result_t blur_avg(logic [8:0][23:0] cells, bit [2:0] row_ok,
                                   bit [2:0] col_ok);
            int          s_red;
            int          s_green;
            int          s_blue;
            int          n;
            logic [23:0] px;
            result_t     res;
            s_red   = 0;
            s_green = 0;
            s_blue  = 0;
            n       = 0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (row_ok[r] && col_ok[c])
                    begin
                        px      = cells[r*3+c];
                        s_red   += int'(px[23:16]);
                        s_green += int'(px[15:8]);
                        s_blue  += int'(px[7:0]);
                        n++;
                    end
                end
            end
            res.red   = 8'((2 * s_red + n) / (2 * n));
            res.green = 8'((2 * s_green + n) / (2 * n));
            res.blue  = 8'((2 * s_blue + n) / (2 * n));
            res.last  = 1'b0;
            return res;
        endfunction

        function void take_pixel(logic func, pixel_t p);
            int               w;
            int               h;
            int               ci;
            int               ri;
            int               ro;
            int               co;
            bit               emit;
            logic [23:0]      px;
            logic [23:0]      up;
            logic [23:0]      mid;
            logic [8:0][23:0] tmp;
            result_t          res;
            w    = eff_width();
            h    = eff_height();
            ri   = row;
            ci   = col;
            emit = 1'b0;
            ro   = 0;
            co   = 0;
            res  = '0;
            // past the last row every item drains, whatever its func
            if (ri >= h)
                px = '0;
            else if (func == FUNC_PIXEL)
                px = p;
            else
                return;
            if (ci >= MAX_WIDTH_DEF)
                ci = 0;

            // right edge of the row two back
            if (ci == 0 && ri >= 2)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    tmp[r*3]   = win[r*3+1];
                    tmp[r*3+1] = win[r*3+2];
                    tmp[r*3+2] = '0;
                end
                res  = blur_avg(tmp, {(ri - 1) < h, 1'b1, ri >= 3}, {1'b0, 1'b1, w >= 2});
                ro   = ri - 2;
                co   = w - 1;
                emit = 1'b1;
            end

            up             = upper_row[ci];
            mid            = middle_row[ci];
            upper_row[ci]  = mid;
            middle_row[ci] = px;
            for (int r = 0; r < 3; r++)
            begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = px;

            if (ci >= 1 && ri >= 1)
            begin
                res  = blur_avg(win, {ri < h, 1'b1, ri >= 2}, {1'b1, 1'b1, ci >= 2});
                ro   = ri - 1;
                co   = ci - 1;
                emit = 1'b1;
            end

            ci++;
            if (ci >= w)
            begin
                ci = 0;
                ri++;
            end
            col = ci;
            row = ri;

            if (!emit)
                return;
            res.last = (ro == h - 1) && (co == w - 1);
            if (res.last)
            begin
                col = 0;
                row = 0;
            end
            blurred_q.push_back(res);
        endfunction

        function void check_blurred(result_t got);
            result_t want;
            if (blurred_q.size() == 0)
            begin
                $display("%0t result with none expected: %h", $time, got);
                errors++;
                return;
            end
            want = blurred_q.pop_front();
            if (got.red !== want.red)
            begin
                $display("%0t out_red expected %0d actual %0d", $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green)
            begin
                $display("%0t out_green expected %0d actual %0d", $time, want.green,
                         got.green);
                errors++;
            end
            if (got.blue !== want.blue)
            begin
                $display("%0t out_blue expected %0d actual %0d", $time, want.blue, got.blue);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t last_of_frame expected %0b actual %0b", $time, want.last,
                         got.last);
                errors++;
            end
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bb3_in_if  pix_if ();
    bb3_out_if blur_if ();

    box_blur_scoreboard blur_sb;
    int                 items_sent;
    int                 stall_cycles;
    bit                 no_idle;

    box_blur_3x3_edge_aware_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_if),
        .blurred (blur_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        blur_if.ready = no_idle || ($urandom_range(99) >= 9);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                blur_sb.take_pixel(pix_if.func,
                                   {pix_if.in_red, pix_if.in_green, pix_if.in_blue});
                stall_cycles = 0;
            end
            else if (blur_if.valid && blur_if.ready)
                stall_cycles = 0;
            else if (psel && penable && pready)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (blur_if.valid && blur_if.ready)
                blur_sb.check_blurred({blur_if.out_red, blur_if.out_green, blur_if.out_blue,
                                       blur_if.last_of_frame});
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        return p;
    endfunction

    task automatic send_item(input logic func, input pixel_t p);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 9)
        begin
            pix_if.valid = 1'b0;
            @(negedge clk);
        end
        pix_if.valid    = 1'b1;
        pix_if.func     = func;
        pix_if.in_red   = p.red;
        pix_if.in_green = p.green;
        pix_if.in_blue  = p.blue;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
    endtask

    // wait for every expected transaction, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        pix_if.valid = 1'b0;
        while (blur_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] readback;
        readback = (idx == REG_WIDTH) ? 32'(value[IMG_WIDTH_W-1:0])
                                      : 32'(value[IMG_HEIGHT_W-1:0]);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        blur_sb.set_reg(idx, value);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== readback)
        begin
            $display("%0t register %0d readback expected %h actual %h", $time, idx,
                     readback, prdata);
            blur_sb.errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic run_frame(input int w, input int h, input bit broken);
        int n;
        n = w * h;
        if (broken)
            n = $urandom_range(1, (n < 120) ? n : 120);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                send_item(FUNC_FLUSH, rand_pixel());
            send_item(FUNC_PIXEL, rand_pixel());
            items_sent++;
            no_idle = (items_sent >= 700) && (items_sent < 1000);
        end
        if (!broken)
        begin
            for (int i = 0; i <= w; i++)
            begin
                send_item(logic'($urandom_range(1)), rand_pixel());
                items_sent++;
            end
            if ($urandom_range(3) == 0)
                send_item(FUNC_FLUSH, rand_pixel());
        end
    endtask

    initial
    begin
        int       wv;
        int       hv;
        int       w;
        int       h;
        int       frames;
        bit       broken;

        blur_sb         = new();
        items_sent      = 0;
        stall_cycles    = 0;
        no_idle         = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix_if.valid    = 1'b0;
        pix_if.func     = FUNC_PIXEL;
        pix_if.in_red   = '0;
        pix_if.in_green = '0;
        pix_if.in_blue  = '0;
        blur_if.ready   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // flush with nothing pending
        send_item(FUNC_FLUSH, 24'hffffff);
        settle();
        reg_write(REG_WIDTH, 32'd3);
        reg_write(REG_HEIGHT, 32'd2);
        send_item(FUNC_FLUSH, 24'h000000);
        send_item(FUNC_PIXEL, 24'hffffff);
        send_item(FUNC_PIXEL, 24'h000000);
        // flush before the frame is complete
        send_item(FUNC_FLUSH, 24'h123456);
        send_item(FUNC_PIXEL, 24'haa55aa);
        send_item(FUNC_PIXEL, 24'h55aa55);
        send_item(FUNC_PIXEL, 24'hff00ff);
        send_item(FUNC_PIXEL, 24'h01fe80);
        send_item(FUNC_FLUSH, 24'h000000);
        send_item(FUNC_PIXEL, 24'hffffff);
        send_item(FUNC_FLUSH, 24'h000000);
        send_item(FUNC_FLUSH, 24'h000000);
        // flush after the frame is done
        send_item(FUNC_FLUSH, 24'h000000);
        settle();
        // zero in both registers means a single pixel
        reg_write(REG_WIDTH, 32'd0);
        reg_write(REG_HEIGHT, 32'd0);
        send_item(FUNC_PIXEL, 24'h807f01);
        send_item(FUNC_FLUSH, 24'h000000);
        send_item(FUNC_PIXEL, 24'hffffff);
        settle();
        reg_write(REG_HEIGHT, 32'd8191);
        reg_write(REG_WIDTH, 32'd2047);
        for (int i = 0; i < 5; i++)
            send_item(FUNC_PIXEL, rand_pixel());
        settle();
        items_sent = 25;

        while (items_sent < ITEM_TARGET)
        begin
            wv = $urandom_range(1, 10);
            hv = $urandom_range(1, 8);
            case ($urandom_range(19))
                0:
                begin
                    case ($urandom_range(3))
                        0:       wv = 0;
                        1:       wv = MAX_WIDTH_DEF;
                        2:       wv = 2047;
                        default: wv = $urandom_range(2047);
                    endcase
                end
                1:
                begin
                    case ($urandom_range(3))
                        0:       hv = 0;
                        1:       hv = MAX_HEIGHT_DEF;
                        2:       hv = 8191;
                        default: hv = $urandom_range(8191);
                    endcase
                end
                2:       wv = $urandom_range(11, 64);
                3:       hv = $urandom_range(9, 20);
                default: ;
            endcase
            if ($urandom_range(1))
            begin
                reg_write(REG_WIDTH, 32'(wv));
                reg_write(REG_HEIGHT, 32'(hv));
            end
            else
            begin
                reg_write(REG_HEIGHT, 32'(hv));
                reg_write(REG_WIDTH, 32'(wv));
            end
            w      = blur_sb.eff_width();
            h      = blur_sb.eff_height();
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                broken = ($urandom_range(9) == 0) || (w * h > FULL_FRAME_MAX);
                run_frame(w, h, broken);
                if (broken)
                    break;
            end
            settle();
        end

        no_idle = 1'b0;
        settle();
        repeat (20) @(posedge clk);
        if (blur_sb.errors == 0 && blur_sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bb3_pkg.sv
src/bb3_in_if.sv
src/bb3_out_if.sv
src/bb3_ram.sv
src/bb3_col_cell.sv
src/bb3_out_fifo.sv
src/box_blur_3x3_edge_aware_unit.sv
tb/box_blur_3x3_edge_aware_unit_tb.sv
